@@ hdl/aligned_area_bounded_resize_assert.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the aligned area bounded resize block
// Immediate-implication and next-cycle-implication property wrappers.
// ---------------------------------------------------------------------------
`ifndef ALIGNED_AREA_BOUNDED_RESIZE_ASSERT_SVH
`define ALIGNED_AREA_BOUNDED_RESIZE_ASSERT_SVH
`ifndef SYNTHESIS
// Consequent must hold in the same cycle as the antecedent.
`define AABR_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("aabr assertion failed");
// Consequent must hold in the cycle after the antecedent.
`define AABR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("aabr assertion failed");
`else
`define AABR_ASSERT_NOW(lbl, ante, cons)
`define AABR_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

@@ hdl/aabr_pkg.sv @@
// ---------------------------------------------------------------------------
// aabr_pkg
// Shared widths, constants and word types of the aligned area bounded resize.
// ---------------------------------------------------------------------------
`default_nettype none

package aabr_pkg;

    // Field and datapath widths.
    localparam int DIM_BITS    = 16;
    localparam int IN_W        = 16;
    localparam int OUT_W       = 17;
    localparam int FACT_W      = 8;
    localparam int AREA_W      = 26;
    localparam int HB_W        = DIM_BITS + 1;
    localparam int NUM_W       = DIM_BITS + AREA_W;
    localparam int DEN_W       = (DIM_BITS > FACT_W) ? DIM_BITS : FACT_W + 1;
    localparam int ROOT_W      = (NUM_W + 1) / 2;
    localparam int SQ_W        = 2 * ROOT_W;
    localparam int RATIO_LIMIT = 200;

    // Configuration port.
    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;
    localparam logic [1:0] REG_GRID_FACTOR = 2'd0;
    localparam logic [1:0] REG_MIN_AREA    = 2'd1;
    localparam logic [1:0] REG_MAX_AREA    = 2'd2;

    // Reset values of the registers.
    localparam logic [FACT_W-1:0] GRID_FACTOR_RST = FACT_W'(28);
    localparam logic [AREA_W-1:0] MIN_AREA_RST    = AREA_W'(3136);
    localparam logic [AREA_W-1:0] MAX_AREA_RST    = AREA_W'(12845056);

    typedef enum logic [1:0] {
        MODE_KEEP,
        MODE_DOWN,
        MODE_UP
    } mode_t;

    // Input and output words.
    typedef struct packed {
        logic [IN_W-1:0] in_height;
        logic [IN_W-1:0] in_width;
    } in_t;

    typedef struct packed {
        logic [OUT_W-1:0] out_height;
        logic [OUT_W-1:0] out_width;
        logic             status;
    } out_t;

    // Control and carried values that travel beside the arithmetic units.
    typedef struct packed {
        logic                valid;
        logic                err;
        mode_t               mode;
        logic [FACT_W-1:0]   f;
        logic [DIM_BITS-1:0] h;
        logic [DIM_BITS-1:0] w;
        logic [HB_W-1:0]     hb;
        logic [HB_W-1:0]     wb;
    } sb_t;

endpackage

`default_nettype wire

@@ hdl/aligned_area_bounded_resize.sv @@
// An accepted input word passes through three pairs of divider pipelines and one pair of
// root pipelines in series, between registered control stages, to the output word.
// Throughput: one word per cycle; the whole pipeline advances together and holds
// while the output word is stalled. Reset clears all valid bits and loads the
// register reset values; no clearing pass is needed.
// ---------------------------------------------------------------------------
// aligned_area_bounded_resize
// Rounds a frame size to a grid and scales it into an area budget.
// ---------------------------------------------------------------------------
`default_nettype none

`include "aligned_area_bounded_resize_assert.svh"

module aligned_area_bounded_resize (
    input  wire                             clk,
    input  wire                             rst_n,
    input  wire                             in_valid,
    output logic                            in_stall,
    input  aabr_pkg::in_t                   in_data,
    output logic                            out_valid,
    input  wire                             out_stall,
    output aabr_pkg::out_t                  out_data,
    input  wire                             psel,
    input  wire                             penable,
    input  wire                             pwrite,
    input  wire  [aabr_pkg::ADDR_W-1:0]     paddr,
    input  wire  [aabr_pkg::DATA_W-1:0]     pwdata,
    output logic [aabr_pkg::DATA_W-1:0]     prdata,
    output logic                            pready
);

    localparam int DB = aabr_pkg::DIM_BITS;
    localparam int FW = aabr_pkg::FACT_W;
    localparam int AW = aabr_pkg::AREA_W;
    localparam int HW = aabr_pkg::HB_W;
    localparam int NW = aabr_pkg::NUM_W;
    localparam int DW = aabr_pkg::DEN_W;
    localparam int RW = aabr_pkg::ROOT_W;
    localparam int OW = aabr_pkg::OUT_W;

    // Configuration registers.
    logic [FW-1:0] grid_factor_reg;
    logic [AW-1:0] min_area_reg;
    logic [AW-1:0] max_area_reg;
    logic [1:0]    reg_idx;
    logic          cfg_write;

    assign pready    = 1'b1;
    assign reg_idx   = paddr[aabr_pkg::ADDR_W-1:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_factor_reg <= aabr_pkg::GRID_FACTOR_RST;
            min_area_reg    <= aabr_pkg::MIN_AREA_RST;
            max_area_reg    <= aabr_pkg::MAX_AREA_RST;
        end
        else if (cfg_write)
        begin
            case (reg_idx)
                aabr_pkg::REG_GRID_FACTOR: grid_factor_reg <= pwdata[FW-1:0];
                aabr_pkg::REG_MIN_AREA:    min_area_reg    <= pwdata[AW-1:0];
                aabr_pkg::REG_MAX_AREA:    max_area_reg    <= pwdata[AW-1:0];
                default:                   ;
            endcase
        end
    end

    // Register read-back.
    always_comb
    begin
        case (reg_idx)
            aabr_pkg::REG_GRID_FACTOR: prdata = aabr_pkg::DATA_W'(grid_factor_reg);
            aabr_pkg::REG_MIN_AREA:    prdata = aabr_pkg::DATA_W'(min_area_reg);
            aabr_pkg::REG_MAX_AREA:    prdata = aabr_pkg::DATA_W'(max_area_reg);
            default:                   prdata = '0;
        endcase
    end

    // Pipeline advance: everything moves unless the output word is stalled.
    logic adv;
    logic out_valid_reg;

    assign adv       = !out_valid_reg || !out_stall;
    assign in_stall  = !adv;
    assign out_valid = out_valid_reg;

    // Stage 1 inputs: dimension checks and effective factor.
    logic [DB-1:0]   h_in;
    logic [DB-1:0]   w_in;
    logic [DB-1:0]   big;
    logic [DB-1:0]   small_dim;
    logic [DB+7:0]   small_x200;
    logic [FW-1:0]   f_eff;
    logic            dim_err;

    assign h_in       = DB'(in_data.in_height);
    assign w_in       = DB'(in_data.in_width);
    assign big        = (h_in > w_in) ? h_in : w_in;
    assign small_dim  = (h_in > w_in) ? w_in : h_in;
    assign small_x200 = (DB+8)'(small_dim) * (DB+8)'(aabr_pkg::RATIO_LIMIT);
    assign dim_err    = (small_dim == '0) || ((DB+8)'(big) > small_x200);
    assign f_eff      = (grid_factor_reg == '0) ? FW'(1) : grid_factor_reg;

    // Stage registers.
    aabr_pkg::sb_t s1_reg, s2_reg, s3_reg, s4_reg, s5_reg, s6_reg, s7_reg, s8_reg;
    aabr_pkg::sb_t s1_next, s2_next, s4_next;
    logic [2*HW-1:0] area_reg;
    logic [AW-1:0]   lim_reg;
    logic [NW-1:0]   ph_reg, pw_reg;
    logic [NW-1:0]   ch_reg, cw_reg;
    logic [RW:0]     sh_reg, sw_reg;
    logic [RW:0]     ah_reg, aw_reg;
    aabr_pkg::out_t  out_reg, out_next;

    // Rounding divider: (2d + f) / (2f).
    logic [NW-1:0]   rnd_num_h, rnd_num_w, rnd_q_h, rnd_q_w;
    logic [DW-1:0]   rnd_den, rnd_r_h, rnd_r_w;
    aabr_pkg::sb_t   sb_rnd, sb_rnd_unused;

    assign rnd_num_h = NW'({s1_reg.h, 1'b0}) + NW'(s1_reg.f);
    assign rnd_num_w = NW'({s1_reg.w, 1'b0}) + NW'(s1_reg.f);
    assign rnd_den   = DW'({s1_reg.f, 1'b0});

    aabr_div u_div_rnd_h (
        .clk(clk), .rst_n(rst_n), .en(adv),
        .num(rnd_num_h), .den(rnd_den), .sb_in(s1_reg),
        .quo(rnd_q_h), .rem(rnd_r_h), .sb_out(sb_rnd)
    );

    aabr_div u_div_rnd_w (
        .clk(clk), .rst_n(rst_n), .en(adv),
        .num(rnd_num_w), .den(rnd_den), .sb_in(s1_reg),
        .quo(rnd_q_w), .rem(rnd_r_w), .sb_out(sb_rnd_unused)
    );

    // Rounded sides.
    logic [HW+FW-1:0] hb_prod, wb_prod;

    assign hb_prod = (HW+FW)'(rnd_q_h[HW-1:0]) * (HW+FW)'(sb_rnd.f);
    assign wb_prod = (HW+FW)'(rnd_q_w[HW-1:0]) * (HW+FW)'(sb_rnd.f);

    // Area divider: d1 * lim / d2.
    logic [NW-1:0]   ar_q_h, ar_q_w;
    logic [DW-1:0]   ar_r_h, ar_r_w;
    aabr_pkg::sb_t   sb_area, sb_area_unused;

    aabr_div u_div_area_h (
        .clk(clk), .rst_n(rst_n), .en(adv),
        .num(ph_reg), .den(DW'(s5_reg.w)), .sb_in(s5_reg),
        .quo(ar_q_h), .rem(ar_r_h), .sb_out(sb_area)
    );

    aabr_div u_div_area_w (
        .clk(clk), .rst_n(rst_n), .en(adv),
        .num(pw_reg), .den(DW'(s5_reg.h)), .sb_in(s5_reg),
        .quo(ar_q_w), .rem(ar_r_w), .sb_out(sb_area_unused)
    );

    logic area_up;
    assign area_up = (sb_area.mode == aabr_pkg::MODE_UP);

    // Square roots of the scaled quotients.
    logic [RW-1:0]   rt_h, rt_w;
    logic            rt_nz_h, rt_nz_w;
    aabr_pkg::sb_t   sb_sqrt, sb_sqrt_unused;

    aabr_isqrt u_sqrt_h (
        .clk(clk), .rst_n(rst_n), .en(adv),
        .x(aabr_pkg::SQ_W'(ch_reg)), .sb_in(s6_reg),
        .root(rt_h), .rem_nz(rt_nz_h), .sb_out(sb_sqrt)
    );

    aabr_isqrt u_sqrt_w (
        .clk(clk), .rst_n(rst_n), .en(adv),
        .x(aabr_pkg::SQ_W'(cw_reg)), .sb_in(s6_reg),
        .root(rt_w), .rem_nz(rt_nz_w), .sb_out(sb_sqrt_unused)
    );

    logic sqrt_up;
    assign sqrt_up = (sb_sqrt.mode == aabr_pkg::MODE_UP);

    // Alignment divider: side / f.
    logic [NW-1:0]   al_q_h, al_q_w;
    logic [DW-1:0]   al_r_h, al_r_w;
    aabr_pkg::sb_t   sb_aln, sb_aln_unused;

    aabr_div u_div_aln_h (
        .clk(clk), .rst_n(rst_n), .en(adv),
        .num(NW'(sh_reg)), .den(DW'(s7_reg.f)), .sb_in(s7_reg),
        .quo(al_q_h), .rem(al_r_h), .sb_out(sb_aln)
    );

    aabr_div u_div_aln_w (
        .clk(clk), .rst_n(rst_n), .en(adv),
        .num(NW'(sw_reg)), .den(DW'(s7_reg.f)), .sb_in(s7_reg),
        .quo(al_q_w), .rem(al_r_w), .sb_out(sb_aln_unused)
    );

    logic aln_up;
    assign aln_up = (sb_aln.mode == aabr_pkg::MODE_UP);

    // Final scaled sides.
    logic [RW+FW:0] oh_prod, ow_prod;

    assign oh_prod = (RW+FW+1)'(ah_reg) * (RW+FW+1)'(s8_reg.f);
    assign ow_prod = (RW+FW+1)'(aw_reg) * (RW+FW+1)'(s8_reg.f);

    // Next values of the sideband stages and the output word.
    always_comb
    begin
        s1_next       = '0;
        s1_next.valid = in_valid;
        s1_next.err   = dim_err;
        s1_next.mode  = aabr_pkg::MODE_KEEP;
        s1_next.f     = f_eff;
        s1_next.h     = h_in;
        s1_next.w     = w_in;

        s2_next    = sb_rnd;
        s2_next.hb = hb_prod[HW-1:0];
        s2_next.wb = wb_prod[HW-1:0];

        s4_next = s3_reg;
        if (area_reg > (2*HW)'(max_area_reg))
        begin
            s4_next.mode = aabr_pkg::MODE_DOWN;
        end
        else if (area_reg < (2*HW)'(min_area_reg))
        begin
            s4_next.mode = aabr_pkg::MODE_UP;
        end
        else
        begin
            s4_next.mode = aabr_pkg::MODE_KEEP;
        end

        out_next.status = s8_reg.err;
        if (s8_reg.err)
        begin
            out_next.out_height = '0;
            out_next.out_width  = '0;
        end
        else if (s8_reg.mode == aabr_pkg::MODE_KEEP)
        begin
            out_next.out_height = OW'(s8_reg.hb);
            out_next.out_width  = OW'(s8_reg.wb);
        end
        else
        begin
            out_next.out_height = OW'(oh_prod);
            out_next.out_width  = OW'(ow_prod);
        end
    end

    // Control stages with valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg        <= '0;
            s2_reg        <= '0;
            s3_reg        <= '0;
            s4_reg        <= '0;
            s5_reg        <= '0;
            s6_reg        <= '0;
            s7_reg        <= '0;
            s8_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_reg        <= s1_next;
            s2_reg        <= s2_next;
            s3_reg        <= s2_reg;
            s4_reg        <= s4_next;
            s5_reg        <= s4_reg;
            s6_reg        <= sb_area;
            s7_reg        <= sb_sqrt;
            s8_reg        <= sb_aln;
            out_valid_reg <= s8_reg.valid;
        end
    end

    // Datapath stages.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            area_reg <= (2*HW)'(s2_reg.hb) * (2*HW)'(s2_reg.wb);
            lim_reg  <= (s4_next.mode == aabr_pkg::MODE_UP) ? min_area_reg : max_area_reg;
            ph_reg   <= NW'(s4_reg.h) * NW'(lim_reg);
            pw_reg   <= NW'(s4_reg.w) * NW'(lim_reg);
            ch_reg   <= ar_q_h + NW'(area_up && (ar_r_h != '0));
            cw_reg   <= ar_q_w + NW'(area_up && (ar_r_w != '0));
            sh_reg   <= (RW+1)'(rt_h) + (RW+1)'(sqrt_up && rt_nz_h);
            sw_reg   <= (RW+1)'(rt_w) + (RW+1)'(sqrt_up && rt_nz_w);
            ah_reg   <= al_q_h[RW:0] + (RW+1)'(aln_up && (al_r_h != '0));
            aw_reg   <= al_q_w[RW:0] + (RW+1)'(aln_up && (al_r_w != '0));
            out_reg  <= out_next;
        end
    end

    assign out_data = out_reg;

    // Both sides of the output word are zero.
    logic out_zero;
    assign out_zero = (out_data.out_height == '0) && (out_data.out_width == '0);

    // Checks.
    `AABR_ASSERT_NOW(a_err_zero, out_valid && out_data.status, out_zero)
    `AABR_ASSERT_NEXT(a_in_load, in_valid && !in_stall, s1_reg.valid)
    `AABR_ASSERT_NEXT(a_stall_hold, in_stall, out_valid)

endmodule

`default_nettype wire

@@ hdl/aabr_div.sv @@
// ---------------------------------------------------------------------------
// aabr_div
// Pipelined restoring divider, one quotient bit per stage, with sideband.
// ---------------------------------------------------------------------------
`default_nettype none

module aabr_div (
    input  wire                            clk,
    input  wire                            rst_n,
    input  wire                            en,
    input  wire  [aabr_pkg::NUM_W-1:0]     num,
    input  wire  [aabr_pkg::DEN_W-1:0]     den,
    input  aabr_pkg::sb_t                  sb_in,
    output logic [aabr_pkg::NUM_W-1:0]     quo,
    output logic [aabr_pkg::DEN_W-1:0]     rem,
    output aabr_pkg::sb_t                  sb_out
);

    localparam int NW = aabr_pkg::NUM_W;
    localparam int DW = aabr_pkg::DEN_W;

    logic [NW-1:0]  nq_reg [NW];
    logic [DW-1:0]  r_reg  [NW];
    logic [DW-1:0]  d_reg  [NW];
    aabr_pkg::sb_t  sb_reg [NW];

    logic [NW-1:0]  nq_next [NW];
    logic [DW-1:0]  r_next  [NW];
    logic [DW-1:0]  d_next  [NW];
    aabr_pkg::sb_t  sb_next [NW];

    // One shift-and-subtract step per stage.
    for (genvar k = 0; k < NW; k++)
    begin : g_stage
        logic [NW-1:0] nq_in;
        logic [DW-1:0] r_in;
        logic [DW-1:0] d_in;
        aabr_pkg::sb_t sb_k;
        logic [DW:0]   t;
        logic          ge;

        if (k == 0)
        begin : g_first
            assign nq_in = num;
            assign r_in  = '0;
            assign d_in  = den;
            assign sb_k  = sb_in;
        end
        else
        begin : g_next
            assign nq_in = nq_reg[k-1];
            assign r_in  = r_reg[k-1];
            assign d_in  = d_reg[k-1];
            assign sb_k  = sb_reg[k-1];
        end

        assign t          = {r_in, nq_in[NW-1]};
        assign ge         = t >= {1'b0, d_in};
        assign nq_next[k] = {nq_in[NW-2:0], ge};
        assign r_next[k]  = ge ? DW'(t - {1'b0, d_in}) : t[DW-1:0];
        assign d_next[k]  = d_in;
        assign sb_next[k] = sb_k;
    end

    // Sideband registers carry the valid bits and are cleared by reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NW; i++)
            begin
                sb_reg[i] <= '0;
            end
        end
        else if (en)
        begin
            for (int i = 0; i < NW; i++)
            begin
                sb_reg[i] <= sb_next[i];
            end
        end
    end

    // Arithmetic registers.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < NW; i++)
            begin
                nq_reg[i] <= nq_next[i];
                r_reg[i]  <= r_next[i];
                d_reg[i]  <= d_next[i];
            end
        end
    end

    assign quo    = nq_reg[NW-1];
    assign rem    = r_reg[NW-1];
    assign sb_out = sb_reg[NW-1];

endmodule

`default_nettype wire

@@ hdl/aabr_isqrt.sv @@
// ---------------------------------------------------------------------------
// aabr_isqrt
// Pipelined integer square root, one root bit per stage, with sideband.
// ---------------------------------------------------------------------------
`default_nettype none

module aabr_isqrt (
    input  wire                            clk,
    input  wire                            rst_n,
    input  wire                            en,
    input  wire  [aabr_pkg::SQ_W-1:0]      x,
    input  aabr_pkg::sb_t                  sb_in,
    output logic [aabr_pkg::ROOT_W-1:0]    root,
    output logic                           rem_nz,
    output aabr_pkg::sb_t                  sb_out
);

    localparam int RW = aabr_pkg::ROOT_W;
    localparam int XW = aabr_pkg::SQ_W;

    logic [XW-1:0]   xs_reg   [RW];
    logic [RW-1:0]   root_reg [RW];
    logic [RW+1:0]   rem_reg  [RW];
    aabr_pkg::sb_t   sb_reg   [RW];

    logic [XW-1:0]   xs_next   [RW];
    logic [RW-1:0]   root_next [RW];
    logic [RW+1:0]   rem_next  [RW];
    aabr_pkg::sb_t   sb_next   [RW];

    // Each stage brings down two radicand bits and decides one root bit.
    for (genvar k = 0; k < RW; k++)
    begin : g_stage
        logic [XW-1:0] xs_in;
        logic [RW-1:0] root_in;
        logic [RW+1:0] rem_in;
        aabr_pkg::sb_t sb_k;
        logic [RW+3:0] r2;
        logic [RW+3:0] trial;
        logic          ge;

        if (k == 0)
        begin : g_first
            assign xs_in   = x;
            assign root_in = '0;
            assign rem_in  = '0;
            assign sb_k    = sb_in;
        end
        else
        begin : g_next
            assign xs_in   = xs_reg[k-1];
            assign root_in = root_reg[k-1];
            assign rem_in  = rem_reg[k-1];
            assign sb_k    = sb_reg[k-1];
        end

        assign r2           = {rem_in, xs_in[XW-1:XW-2]};
        assign trial        = (RW+4)'({root_in, 2'b01});
        assign ge           = r2 >= trial;
        assign xs_next[k]   = {xs_in[XW-3:0], 2'b00};
        assign root_next[k] = {root_in[RW-2:0], ge};
        assign rem_next[k]  = ge ? (RW+2)'(r2 - trial) : r2[RW+1:0];
        assign sb_next[k]   = sb_k;
    end

    // Sideband registers carry the valid bits and are cleared by reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < RW; i++)
            begin
                sb_reg[i] <= '0;
            end
        end
        else if (en)
        begin
            for (int i = 0; i < RW; i++)
            begin
                sb_reg[i] <= sb_next[i];
            end
        end
    end

    // Arithmetic registers.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < RW; i++)
            begin
                xs_reg[i]   <= xs_next[i];
                root_reg[i] <= root_next[i];
                rem_reg[i]  <= rem_next[i];
            end
        end
    end

    assign root   = root_reg[RW-1];
    assign rem_nz = |rem_reg[RW-1];
    assign sb_out = sb_reg[RW-1];

endmodule

`default_nettype wire
